@@ rtl/xcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XCP command slave package
// Command codes, response codes, sizes and the control types shared by the
// decoder, the address unit, the calibration memory and the top level.
// ----------------------------------------------------------------------------
package xcs_pkg;

    // Packet geometry and calibration memory size. The depth is a power of two.
    localparam int PACKET_BYTES = 8;
    localparam int MAX_XFER     = PACKET_BYTES - 1;
    localparam int MEM_DEPTH    = 1024;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);

    // Command codes.
    localparam logic [7:0] CMD_CONNECT      = 8'hFF;
    localparam logic [7:0] CMD_DISCONNECT   = 8'hFE;
    localparam logic [7:0] CMD_GET_STATUS   = 8'hFD;
    localparam logic [7:0] CMD_SYNCH        = 8'hFC;
    localparam logic [7:0] CMD_SET_MTA      = 8'hF6;
    localparam logic [7:0] CMD_UPLOAD       = 8'hF5;
    localparam logic [7:0] CMD_UPLOAD_AT    = 8'hF4;
    localparam logic [7:0] CMD_DOWNLOAD     = 8'hF0;

    // Response packet identifiers and error codes.
    localparam logic [7:0] RESP_POS      = 8'hFF;
    localparam logic [7:0] RESP_ERR      = 8'hFE;
    localparam logic [7:0] ERR_SHORT     = 8'h00;
    localparam logic [7:0] ERR_UNKNOWN   = 8'h20;
    localparam logic [7:0] ERR_RANGE     = 8'h22;
    localparam logic [7:0] ERR_MTA_ZERO  = 8'h25;
    localparam logic [7:0] CONNECT_FLAGS = 8'h01;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_WRITE,
        ST_RESP
    } state_t;

    // What the sequencer does with an accepted command word.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_RESP,
        ACT_READ,
        ACT_WRITE
    } action_t;

    typedef enum logic [1:0] {
        MTA_KEEP,
        MTA_CLEAR,
        MTA_LOAD,
        MTA_ADVANCE
    } mta_op_t;

    typedef enum logic [1:0] {
        OPEN_KEEP,
        OPEN_SET,
        OPEN_CLEAR
    } open_op_t;

    typedef enum logic {
        BASE_MTA,
        BASE_PKT
    } base_sel_t;

    // Decoded command handed from the decoder to the sequencer.
    typedef struct packed {
        action_t          action;
        mta_op_t          mta_op;
        open_op_t         open_op;
        base_sel_t        base_sel;
        logic [2:0]       size;
        logic [3:0]       resp_len;
        logic [7:0][7:0]  resp_bytes;
    } cmd_dec_t;

endpackage

@@ rtl/xcs_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XCP command decoder
// Checks one command word against its length and range rules and gives the
// action, state updates and the immediate response bytes.
// ----------------------------------------------------------------------------
module xcs_decode
(
    input  logic [3:0]        cmd_len,
    input  logic [7:0]        req_type,
    input  logic [7:0]        arg1,
    input  logic [7:0]        arg4,
    input  logic [7:0]        arg5,
    input  logic [7:0]        arg6,
    input  logic [7:0]        arg7,
    input  logic              mta_zero,
    input  logic              session_open,
    output xcs_pkg::cmd_dec_t dec
);

    import xcs_pkg::*;

    logic [3:0]  len;
    logic [31:0] pkt_addr;
    logic        size_ok;
    logic        dl_short;

    always_comb
    begin
        // Saturate the length and gather the packet address.
        len      = (cmd_len > 4'(PACKET_BYTES)) ? 4'(PACKET_BYTES) : cmd_len;
        pkt_addr = {arg7, arg6, arg5, arg4};
        size_ok  = (arg1 <= 8'(MAX_XFER));
        dl_short = (len < 4'd2) || ({5'd0, len} < (9'd2 + {1'b0, arg1}));

        dec            = '0;
        dec.action     = ACT_RESP;
        dec.mta_op     = MTA_KEEP;
        dec.open_op    = OPEN_KEEP;
        dec.base_sel   = BASE_MTA;
        dec.size       = arg1[2:0];
        dec.resp_len   = 4'd1;
        dec.resp_bytes[0] = RESP_POS;

        case (req_type)
            CMD_CONNECT:
            begin
                dec.resp_bytes[1] = CONNECT_FLAGS;
                dec.resp_bytes[3] = 8'(PACKET_BYTES);
                dec.resp_bytes[4] = 8'(PACKET_BYTES);
                dec.resp_bytes[5] = CONNECT_FLAGS;
                dec.resp_bytes[6] = CONNECT_FLAGS;
                dec.resp_len      = 4'd7;
                dec.open_op       = OPEN_SET;
            end
            CMD_DISCONNECT:
            begin
                dec.open_op = OPEN_CLEAR;
                dec.mta_op  = MTA_CLEAR;
            end
            CMD_GET_STATUS:
            begin
                dec.resp_bytes[1] = {7'd0, session_open};
                dec.resp_len      = 4'd5;
            end
            CMD_SET_MTA:
            begin
                if (len < 4'(PACKET_BYTES))
                begin
                    dec.resp_bytes[0] = RESP_ERR;
                    dec.resp_bytes[1] = ERR_SHORT;
                    dec.resp_len      = 4'd2;
                end
                else
                begin
                    dec.mta_op = MTA_LOAD;
                end
            end
            CMD_UPLOAD:
            begin
                if (len < 4'd2)
                begin
                    dec.resp_bytes[0] = RESP_ERR;
                    dec.resp_bytes[1] = ERR_SHORT;
                    dec.resp_len      = 4'd2;
                end
                else if (!size_ok)
                begin
                    dec.resp_bytes[0] = RESP_ERR;
                    dec.resp_bytes[1] = ERR_RANGE;
                    dec.resp_len      = 4'd2;
                end
                else
                begin
                    dec.resp_len = {1'b0, arg1[2:0]} + 4'd1;
                    // A zero MTA reads back zeros and stays where it is.
                    if (!mta_zero)
                    begin
                        dec.mta_op = MTA_ADVANCE;
                        if (arg1[2:0] != 3'd0)
                        begin
                            dec.action = ACT_READ;
                        end
                    end
                end
            end
            CMD_UPLOAD_AT:
            begin
                if (len < 4'(PACKET_BYTES))
                begin
                    dec.resp_bytes[0] = RESP_ERR;
                    dec.resp_bytes[1] = ERR_SHORT;
                    dec.resp_len      = 4'd2;
                end
                else if (!size_ok)
                begin
                    dec.resp_bytes[0] = RESP_ERR;
                    dec.resp_bytes[1] = ERR_RANGE;
                    dec.resp_len      = 4'd2;
                end
                else
                begin
                    dec.resp_len = {1'b0, arg1[2:0]} + 4'd1;
                    dec.base_sel = BASE_PKT;
                    if ((pkt_addr != 32'd0) && (arg1[2:0] != 3'd0))
                    begin
                        dec.action = ACT_READ;
                    end
                end
            end
            CMD_DOWNLOAD:
            begin
                if (dl_short)
                begin
                    dec.resp_bytes[0] = RESP_ERR;
                    dec.resp_bytes[1] = ERR_SHORT;
                    dec.resp_len      = 4'd2;
                end
                else if (mta_zero)
                begin
                    dec.resp_bytes[0] = RESP_ERR;
                    dec.resp_bytes[1] = ERR_MTA_ZERO;
                    dec.resp_len      = 4'd2;
                end
                else
                begin
                    dec.mta_op = MTA_ADVANCE;
                    if (arg1[2:0] != 3'd0)
                    begin
                        dec.action = ACT_WRITE;
                    end
                end
            end
            CMD_SYNCH:
            begin
                dec.resp_bytes[0] = RESP_ERR;
                dec.resp_bytes[1] = ERR_SHORT;
                dec.resp_len      = 4'd2;
            end
            default:
            begin
                dec.resp_bytes[0] = RESP_ERR;
                dec.resp_bytes[1] = ERR_UNKNOWN;
                dec.resp_len      = 4'd2;
            end
        endcase

        // An empty packet is dropped without any effect.
        if (len == 4'd0)
        begin
            dec.action  = ACT_NONE;
            dec.mta_op  = MTA_KEEP;
            dec.open_op = OPEN_KEEP;
        end
    end

endmodule

@@ rtl/xcs_addr_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XCP address unit
// The one shared 32-bit adder: it steps through transfer addresses and
// advances the MTA, and it gives the memory index of the sum.
// ----------------------------------------------------------------------------
module xcs_addr_unit
(
    input  logic [31:0]               base,
    input  logic [2:0]                offset,
    output logic [31:0]               sum,
    output logic [xcs_pkg::MEM_AW-1:0] mem_index
);

    import xcs_pkg::*;

    // The address wraps modulo 2^32; the index is the low part of the sum.
    assign sum       = base + {29'd0, offset};
    assign mem_index = sum[MEM_AW-1:0];

endmodule

@@ rtl/xcs_cal_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XCP calibration memory
// Single-port byte memory with a registered read.
// ----------------------------------------------------------------------------
module xcs_cal_mem
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [xcs_pkg::MEM_AW-1:0] addr,
    input  logic [7:0]                 wdata,
    output logic [7:0]                 rdata
);

    import xcs_pkg::*;

    logic [7:0] mem [MEM_DEPTH];

    // Write or read one byte per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/xcp_command_slave.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XCP command slave
// Takes one command word, runs it against the session flag, the MTA and
// the calibration memory, and returns one response word.
// ----------------------------------------------------------------------------
// After reset the block writes zeros into all MEM_DEPTH locations of the
// calibration memory and holds in_stall high during that pass. Afterwards it
// works on one command at a time: in_stall is low only while idle. A command
// without memory traffic shows its response the cycle after it is accepted.
// UPLOAD and the upload from an address in the packet read their bytes in
// turn, wait in a drain state for the registered read data and then show the
// response; DOWNLOAD writes its bytes in turn before the response appears.
// Each command frees the block the cycle after its response is taken. This
// pace comes from the single memory port and the one shared address adder,
// which handle one byte per cycle. An empty packet is consumed and gives no
// response.
// ----------------------------------------------------------------------------
module xcp_command_slave
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] cmd_len,
    input  logic [7:0] req_type,
    input  logic [7:0] arg1,
    input  logic [7:0] arg2,
    input  logic [7:0] arg3,
    input  logic [7:0] arg4,
    input  logic [7:0] arg5,
    input  logic [7:0] arg6,
    input  logic [7:0] arg7,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] resp_len,
    output logic [7:0] resp0,
    output logic [7:0] resp1,
    output logic [7:0] resp2,
    output logic [7:0] resp3,
    output logic [7:0] resp4,
    output logic [7:0] resp5,
    output logic [7:0] resp6,
    output logic [7:0] resp7
);

    import xcs_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic              session_open_reg;
    logic [31:0]       mta_reg;
    logic [31:0]       base_reg;
    logic [2:0]        size_reg;
    logic [2:0]        idx_reg;
    logic              pend_reg;
    logic [2:0]        pend_idx_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [7:0]        data_reg [6];
    logic [3:0]        resp_len_reg;
    logic [7:0]        resp_byte_reg [8];

    cmd_dec_t          dec;
    logic              in_accept;
    logic              last_step;
    logic [31:0]       add_base;
    logic [2:0]        add_offset;
    logic [31:0]       add_sum;
    logic [MEM_AW-1:0] add_index;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    // Command decode from the input word.
    xcs_decode u_decode
    (
        .cmd_len      (cmd_len),
        .req_type     (req_type),
        .arg1         (arg1),
        .arg4         (arg4),
        .arg5         (arg5),
        .arg6         (arg6),
        .arg7         (arg7),
        .mta_zero     (mta_reg == 32'd0),
        .session_open (session_open_reg),
        .dec          (dec)
    );

    // Shared adder: MTA advance while idle, byte addresses during transfers.
    assign add_base   = (state_reg == ST_IDLE) ? mta_reg : base_reg;
    assign add_offset = (state_reg == ST_IDLE) ? arg1[2:0] : idx_reg;

    xcs_addr_unit u_addr
    (
        .base      (add_base),
        .offset    (add_offset),
        .sum       (add_sum),
        .mem_index (add_index)
    );

    xcs_cal_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign in_accept = in_valid && !in_stall;
    assign last_step = (idx_reg == (size_reg - 3'd1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == {MEM_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (dec.action)
                        ACT_RESP:  state_next = ST_RESP;
                        ACT_READ:  state_next = ST_READ;
                        ACT_WRITE: state_next = ST_WRITE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                if (last_step)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESP;
            end
            ST_WRITE:
            begin
                if (last_step)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory port controls.
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = add_index;
        mem_wdata = data_reg[idx_reg];
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = 8'd0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            session_open_reg <= 1'b0;
            mta_reg          <= 32'd0;
            clr_cnt_reg      <= '0;
            idx_reg          <= 3'd0;
            pend_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            end

            if (in_accept)
            begin
                idx_reg  <= 3'd0;
                case (dec.open_op)
                    OPEN_SET:   session_open_reg <= 1'b1;
                    OPEN_CLEAR: session_open_reg <= 1'b0;
                    default:    session_open_reg <= session_open_reg;
                endcase
                case (dec.mta_op)
                    MTA_CLEAR:   mta_reg <= 32'd0;
                    MTA_LOAD:    mta_reg <= {arg7, arg6, arg5, arg4};
                    MTA_ADVANCE: mta_reg <= add_sum;
                    default:     mta_reg <= mta_reg;
                endcase
            end

            // Step the byte counter; a read leaves one byte in flight.
            if ((state_reg == ST_READ) || (state_reg == ST_WRITE))
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            pend_reg <= (state_reg == ST_READ);
        end
    end

    // Command and response words.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            base_reg     <= (dec.base_sel == BASE_PKT) ? {arg7, arg6, arg5, arg4}
                                                       : mta_reg;
            size_reg     <= dec.size;
            data_reg[0]  <= arg2;
            data_reg[1]  <= arg3;
            data_reg[2]  <= arg4;
            data_reg[3]  <= arg5;
            data_reg[4]  <= arg6;
            data_reg[5]  <= arg7;
            resp_len_reg <= dec.resp_len;
            for (int i = 0; i < 8; i++)
            begin
                resp_byte_reg[i] <= dec.resp_bytes[i];
            end
        end

        if (state_reg == ST_READ)
        begin
            pend_idx_reg <= idx_reg;
        end

        // Place the byte read in the previous cycle.
        if (pend_reg)
        begin
            resp_byte_reg[pend_idx_reg + 3'd1] <= mem_rdata;
        end
    end

    assign resp_len = resp_len_reg;
    assign resp0    = resp_byte_reg[0];
    assign resp1    = resp_byte_reg[1];
    assign resp2    = resp_byte_reg[2];
    assign resp3    = resp_byte_reg[3];
    assign resp4    = resp_byte_reg[4];
    assign resp5    = resp_byte_reg[5];
    assign resp6    = resp_byte_reg[6];
    assign resp7    = resp_byte_reg[7];

endmodule

@@ verif/tb_xcp_command_slave.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XCP command slave testbench
// Feeds command words through the valid/stall input channel, predicts each
// response from a behavioral copy of the session flag, the MTA and the
// calibration memory, and checks every response word field by field. Both
// channels idle and stall in random bursts, with one long receiver hold-off
// and one sender pause until all responses are back.
// ----------------------------------------------------------------------------
module tb_xcp_command_slave;

    import xcs_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 5;
    localparam int RANDOM_WORDS     = 1880;
    localparam int PAUSE_AT_WORD    = 900;
    localparam int QUIET_WORDS      = 150;
    localparam int LONG_HOLD_AFTER  = 400;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 32;
    localparam int WATCHDOG_LIMIT   = 4000;

    // Version bytes returned by CONNECT.
    localparam logic [7:0] LAYER_VERSION = 8'h01;

    // One command word as queued for the driver. A word with pause set is
    // not sent: it makes the sender wait until every response has arrived.
    typedef struct packed {
        logic            pause;
        logic [3:0]      len;
        logic [7:0][7:0] pkt;
    } cmd_word_t;

    typedef struct packed {
        logic [3:0]      len;
        logic [7:0][7:0] rsp;
    } resp_word_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       out_stall = 1'b0;
    cmd_word_t  cur_cmd   = '0;
    logic       in_stall;
    logic       out_valid;
    logic [3:0] cmd_len;
    logic [7:0] req_type, arg1, arg2, arg3, arg4, arg5, arg6, arg7;
    logic [3:0] resp_len;
    logic [7:0] resp0, resp1, resp2, resp3, resp4, resp5, resp6, resp7;

    // Behavioral copy of the block state.
    logic       link_open;
    logic [31:0] mta;
    logic [7:0] cal_mem [MEM_DEPTH];

    cmd_word_t   command_queue[$];
    resp_word_t  pending_responses[$];
    int unsigned errors       = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles  = 0;
    bit          word_taken   = 1'b0;
    bit          waiting_pause = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned stall_left   = 0;
    bit          long_hold_done = 1'b0;

    assign cmd_len  = cur_cmd.len;
    assign req_type = cur_cmd.pkt[0];
    assign arg1     = cur_cmd.pkt[1];
    assign arg2     = cur_cmd.pkt[2];
    assign arg3     = cur_cmd.pkt[3];
    assign arg4     = cur_cmd.pkt[4];
    assign arg5     = cur_cmd.pkt[5];
    assign arg6     = cur_cmd.pkt[6];
    assign arg7     = cur_cmd.pkt[7];

    xcp_command_slave dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd_len   (cmd_len),
        .req_type  (req_type),
        .arg1      (arg1),
        .arg2      (arg2),
        .arg3      (arg3),
        .arg4      (arg4),
        .arg5      (arg5),
        .arg6      (arg6),
        .arg7      (arg7),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .resp_len  (resp_len),
        .resp0     (resp0),
        .resp1     (resp1),
        .resp2     (resp2),
        .resp3     (resp3),
        .resp4     (resp4),
        .resp5     (resp5),
        .resp6     (resp6),
        .resp7     (resp7)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Error response: two bytes, the error identifier and the code.
    function automatic resp_word_t error_word(input logic [7:0] code);
        resp_word_t r;
        r = '0;
        r.len = 4'd2;
        r.rsp[0] = RESP_ERR;
        r.rsp[1] = code;
        return r;
    endfunction

    // Positive upload response. A base address of zero reads back zeros.
    function automatic resp_word_t upload_word(input logic [31:0] base,
                                               input int unsigned size);
        resp_word_t  r;
        logic [31:0] a;
        r = '0;
        r.len = 4'(size + 1);
        r.rsp[0] = RESP_POS;
        for (int i = 0; i < size; i++)
        begin
            a = base + 32'(i);
            if (base != 32'h0)
                r.rsp[1 + i] = cal_mem[a[MEM_AW-1:0]];
        end
        return r;
    endfunction

    // Runs one accepted command against the behavioral state and gives the
    // response it must produce, if any.
    task automatic apply_command(input cmd_word_t c, output bit answered,
                                 output resp_word_t r);
        int unsigned n;
        int unsigned size;
        logic [31:0] a;
        answered = 1'b0;
        r = '0;
        n = (c.len > PACKET_BYTES) ? PACKET_BYTES : c.len;
        if (n == 0)
            return;
        answered = 1'b1;
        size = c.pkt[1];
        r.len = 4'd1;
        r.rsp[0] = RESP_POS;
        case (c.pkt[0])
            CMD_CONNECT:
            begin
                r.len = 4'd7;
                r.rsp[1] = CONNECT_FLAGS;
                r.rsp[3] = 8'(PACKET_BYTES);
                r.rsp[4] = 8'(PACKET_BYTES);
                r.rsp[5] = LAYER_VERSION;
                r.rsp[6] = LAYER_VERSION;
                link_open = 1'b1;
            end
            CMD_DISCONNECT:
            begin
                link_open = 1'b0;
                mta = 32'h0;
            end
            CMD_GET_STATUS:
            begin
                r.len = 4'd5;
                r.rsp[1] = {7'd0, link_open};
            end
            CMD_SET_MTA:
            begin
                if (n < 8)
                    r = error_word(ERR_SHORT);
                else
                    mta = c.pkt[7:4];
            end
            CMD_UPLOAD:
            begin
                if (n < 2)
                    r = error_word(ERR_SHORT);
                else if (size > MAX_XFER)
                    r = error_word(ERR_RANGE);
                else
                begin
                    r = upload_word(mta, size);
                    if (mta != 32'h0)
                        mta = mta + 32'(size);
                end
            end
            CMD_UPLOAD_AT:
            begin
                if (n < 8)
                    r = error_word(ERR_SHORT);
                else if (size > MAX_XFER)
                    r = error_word(ERR_RANGE);
                else
                    r = upload_word(c.pkt[7:4], size);
            end
            CMD_DOWNLOAD:
            begin
                if (n < 2 || n < 2 + size)
                    r = error_word(ERR_SHORT);
                else if (mta == 32'h0)
                    r = error_word(ERR_MTA_ZERO);
                else
                begin
                    for (int i = 0; i < size; i++)
                    begin
                        a = mta + 32'(i);
                        cal_mem[a[MEM_AW-1:0]] = c.pkt[2 + i];
                    end
                    mta = mta + 32'(size);
                end
            end
            CMD_SYNCH:
                r = error_word(ERR_SHORT);
            default:
                r = error_word(ERR_UNKNOWN);
        endcase
    endtask

    // Builds a command word; bytes 2 and 3 get random content.
    function automatic cmd_word_t make_word(input int unsigned len, input logic [7:0] code,
                                            input int unsigned size, input logic [31:0] addr);
        cmd_word_t w;
        w = '0;
        w.len = 4'(len);
        w.pkt[0] = code;
        w.pkt[1] = 8'(size);
        w.pkt[2] = 8'($urandom_range(0, 255));
        w.pkt[3] = 8'($urandom_range(0, 255));
        w.pkt[7:4] = addr;
        return w;
    endfunction

    // Addresses mostly fall in a small window of memory slots so that reads
    // hit written data; some are zero, some wrap around the top.
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        a = $urandom;
        case ($urandom_range(0, 9))
            0: a = 32'h0;
            1: a = 32'hFFFF_FFF8 | 32'($urandom_range(0, 7));
            2, 3: a = $urandom;
            default: a = (a & ~32'(MEM_DEPTH - 1)) | 32'($urandom_range(1, 63));
        endcase
        return a;
    endfunction

    // Random command, mostly well formed, sometimes with a broken length.
    function automatic cmd_word_t random_word();
        int unsigned sel;
        int unsigned size;
        cmd_word_t   w;
        sel  = $urandom_range(0, 99);
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        if (sel < 5)
            w = make_word($urandom_range(1, 8), CMD_CONNECT, size, $urandom);
        else if (sel < 8)
            w = make_word($urandom_range(1, 8), CMD_DISCONNECT, size, $urandom);
        else if (sel < 13)
            w = make_word($urandom_range(1, 8), CMD_GET_STATUS, size, $urandom);
        else if (sel < 16)
            w = make_word($urandom_range(1, 8), CMD_SYNCH, size, $urandom);
        else if (sel < 31)
            w = make_word(8, CMD_SET_MTA, size, pick_address());
        else if (sel < 51)
            w = make_word($urandom_range(2, 8), CMD_UPLOAD, size, $urandom);
        else if (sel < 66)
            w = make_word(8, CMD_UPLOAD_AT, size, pick_address());
        else if (sel < 91)
        begin
            if (size > 6 && size < 8)
                size = $urandom_range(0, 6);
            w = make_word((size > 6) ? 8 : $urandom_range(2 + size, 8), CMD_DOWNLOAD,
                          size, $urandom);
        end
        else
            w = make_word($urandom_range(1, 8), 8'($urandom_range(0, 255)), size, $urandom);
        if ($urandom_range(0, 9) == 0)
            w.len = 4'($urandom_range(0, 15));
        return w;
    endfunction

    // Stimulus, reset and end of run.
    initial
    begin
        cmd_word_t w;
        link_open = 1'b0;
        mta = 32'h0;
        foreach (cal_mem[i])
            cal_mem[i] = 8'h00;

        // Directed words: empty packet, status before and after connect,
        // transfers with a zero MTA, address wrap, size and length errors,
        // SYNCH, an unknown code, an overlong length and disconnect.
        command_queue.push_back(make_word(0, CMD_CONNECT, 0, $urandom));
        command_queue.push_back(make_word(1, CMD_GET_STATUS, 0, $urandom));
        command_queue.push_back(make_word(1, CMD_CONNECT, 0, $urandom));
        command_queue.push_back(make_word(1, CMD_GET_STATUS, 0, $urandom));
        command_queue.push_back(make_word(2, CMD_UPLOAD, 7, $urandom));
        command_queue.push_back(make_word(8, CMD_DOWNLOAD, 6, $urandom));
        command_queue.push_back(make_word(7, CMD_SET_MTA, 0, 32'h0000_0010));
        command_queue.push_back(make_word(8, CMD_SET_MTA, 0, 32'hFFFF_FFFE));
        command_queue.push_back(make_word(8, CMD_DOWNLOAD, 6, $urandom));
        command_queue.push_back(make_word(8, CMD_SET_MTA, 0, 32'hFFFF_FFFE));
        command_queue.push_back(make_word(2, CMD_UPLOAD, 7, $urandom));
        command_queue.push_back(make_word(8, CMD_UPLOAD, 8, $urandom));
        command_queue.push_back(make_word(1, CMD_UPLOAD, 7, $urandom));
        command_queue.push_back(make_word(8, CMD_UPLOAD_AT, 7, 32'h0));
        command_queue.push_back(make_word(8, CMD_UPLOAD_AT, 7, 32'hFFFF_FFFE));
        command_queue.push_back(make_word(7, CMD_UPLOAD_AT, 7, 32'hFFFF_FFFE));
        command_queue.push_back(make_word(8, CMD_UPLOAD_AT, 255, 32'h0000_0001));
        command_queue.push_back(make_word(1, CMD_DOWNLOAD, 0, $urandom));
        command_queue.push_back(make_word(8, CMD_DOWNLOAD, 7, $urandom));
        command_queue.push_back(make_word(2, CMD_DOWNLOAD, 0, $urandom));
        command_queue.push_back(make_word(8, CMD_SYNCH, 0, $urandom));
        command_queue.push_back(make_word(8, 8'h00, 0, $urandom));
        command_queue.push_back(make_word(15, CMD_CONNECT, 0, $urandom));
        command_queue.push_back(make_word(1, CMD_DISCONNECT, 0, $urandom));
        command_queue.push_back(make_word(2, CMD_UPLOAD, 3, $urandom));

        // Random words, with a few empty packets mixed in and one pause.
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if ($urandom_range(0, 49) == 0)
                command_queue.push_back(make_word(0, 8'($urandom_range(0, 255)),
                                                  $urandom_range(0, 255), $urandom));
            if (k == PAUSE_AT_WORD)
            begin
                w = '0;
                w.pause = 1'b1;
                command_queue.push_back(w);
            end
            command_queue.push_back(random_word());
        end

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        while (command_queue.size() != 0 || in_valid || pending_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb_xcp_command_slave passed");
        else
            $display("tb_xcp_command_slave failed");
        $finish;
    end

    // Input driver: holds a stalled word, otherwise idles or sends the next one.
    always @(negedge clk)
    begin
        cmd_word_t nxt;
        if (rst_n)
        begin
            if (in_valid && !word_taken)
            begin
                // Stalled: the word stays on the bus.
            end
            else if (waiting_pause)
            begin
                in_valid <= 1'b0;
                if (pending_responses.size() == 0)
                    waiting_pause = 1'b0;
            end
            else if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (command_queue.size() >= QUIET_WORDS && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 15);
                in_valid <= 1'b0;
            end
            else if (command_queue.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                nxt = command_queue.pop_front();
                if (nxt.pause)
                begin
                    waiting_pause = 1'b1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_cmd  <= nxt;
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Receiver: random stall bursts and one long hold-off.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER)
        begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (command_queue.size() >= QUIET_WORDS && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: predicts on each accepted command word, checks each response
    // word against the oldest expectation, and watches for a hang.
    always @(posedge clk)
    begin : monitor
        bit         answered;
        bit         resp_fire;
        resp_word_t want;
        resp_word_t got;
        if (rst_n)
        begin
            word_taken = in_valid && !in_stall;
            resp_fire  = out_valid && !out_stall;
            if (word_taken)
            begin
                apply_command(cur_cmd, answered, want);
                if (answered)
                    pending_responses.push_back(want);
            end
            if (resp_fire)
            begin
                results_seen++;
                got.len = resp_len;
                got.rsp = {resp7, resp6, resp5, resp4, resp3, resp2, resp1, resp0};
                if (pending_responses.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response, len %0d bytes %h", $time,
                             got.len, got.rsp);
                end
                else
                begin
                    want = pending_responses.pop_front();
                    if (got.len !== want.len)
                    begin
                        errors++;
                        $display("%0t: resp_len expected %0d, got %0d", $time,
                                 want.len, got.len);
                    end
                    for (int i = 0; i < PACKET_BYTES; i++)
                    begin
                        if (got.rsp[i] !== want.rsp[i])
                        begin
                            errors++;
                            $display("%0t: resp%0d expected %h, got %h", $time, i,
                                     want.rsp[i], got.rsp[i]);
                        end
                    end
                end
            end
            if (word_taken || resp_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("tb_xcp_command_slave failed");
                $finish;
            end
        end
    end

endmodule

@@ sim.f @@
rtl/xcs_pkg.sv
rtl/xcs_decode.sv
rtl/xcs_addr_unit.sv
rtl/xcs_cal_mem.sv
rtl/xcp_command_slave.sv
verif/tb_xcp_command_slave.sv
